>>> design/assert_macros.svh
// Assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/b64d_pkg.sv
package b64d_pkg;

    // Queue between classifier and serialiser (power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [FIFO_AW:0]   FIFO_FULL_COUNT = (FIFO_AW + 1)'(FIFO_DEPTH);
    localparam logic [FIFO_AW-1:0] FIFO_LAST_SLOT  = FIFO_AW'(FIFO_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_BADLEN  = 2'd2,
        ST_BADPAD  = 2'd3
    } status_t;

    typedef struct packed {
        logic       is_pad;
        logic       is_bad;
        logic [5:0] value;
    } sextet_t;

    // One queue entry: the bytes of a completed quartet and/or the final status
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  nbytes;
        logic        has_status;
        status_t     code;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   avail;
        entry_t entry;
    } head_t;

    // Map one character to its sextet, or flag padding / a bad code
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] t;
        s = '0;
        t = '0;
        if (c inside {[8'h41:8'h5A]})           // upper case letters
        begin
            t = c - 8'h41;
            s.value = t[5:0];
        end
        else if (c inside {[8'h61:8'h7A]})      // lower case letters
        begin
            t = c - 8'h61 + 8'd26;
            s.value = t[5:0];
        end
        else if (c inside {[8'h30:8'h39]})      // digits
        begin
            t = c - 8'h30 + 8'd52;
            s.value = t[5:0];
        end
        else if (c == 8'h2B)                    // plus
        begin
            s.value = 6'd62;
        end
        else if (c == 8'h2F)                    // slash
        begin
            s.value = 6'd63;
        end
        else if (c == 8'h3D)                    // padding
        begin
            s.is_pad = 1'b1;
        end
        else
        begin
            s.is_bad = 1'b1;
        end
        return s;
    endfunction

endpackage

>>> design/b64d_if.sv
// Input channel: one character per transaction
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// Output channel: one data byte or the final status per transaction
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_status;
    logic [1:0] status_code;
    logic       last_result;

    modport source (output valid, output data_byte, output is_status,
                    output status_code, output last_result, input ready);
    modport sink   (input valid, input data_byte, input is_status,
                    input status_code, input last_result, output ready);
endinterface

>>> design/b64d_front.sv
`include "assert_macros.svh"

module b64d_front (
    input  logic            clk,
    input  logic            rst_n,
    b64d_in_if.sink         in_ch,
    input  logic            full,
    output b64d_pkg::push_t push_o
);
    import b64d_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pad_reg, pad_next;
    status_t     err_reg, err_next;

    logic        in_acc;
    logic        last;
    sextet_t     sx;
    logic [5:0]  value;
    status_t     err_mid, err_fin;
    logic [1:0]  pad_mid, pos_mid;
    logic [17:0] acc_mid;
    logic [23:0] word;
    logic [1:0]  nbytes;

    // Take a character whenever the queue has room
    assign in_ch.ready = !full;
    assign in_acc      = in_ch.valid && in_ch.ready;

    // Classify the character and advance the quartet
    always_comb
    begin
        last    = in_ch.end_of_text;
        sx      = sextet_of(in_ch.char_code);
        err_mid = err_reg;
        pad_mid = pad_reg;
        pos_mid = pos_reg;
        acc_mid = acc_reg;
        word    = '0;
        nbytes  = 2'd0;
        value   = sx.is_pad ? 6'd0 : sx.value;

        if (err_reg == ST_OK)
        begin
            if (sx.is_bad)
            begin
                err_mid = ST_BADCHAR;
            end
            else if (sx.is_pad)
            begin
                if (pos_reg < 2'd2 || (pos_reg == 2'd3 && !last))
                begin
                    err_mid = ST_BADPAD;
                end
                else
                begin
                    pad_mid = pad_reg + 2'd1;
                end
            end
            else if (pad_reg != 2'd0)
            begin
                err_mid = ST_BADPAD;
            end
        end

        if (err_mid == ST_OK)
        begin
            if (pos_reg != 2'd3)
            begin
                acc_mid = {acc_reg[11:0], value};
                pos_mid = pos_reg + 2'd1;
            end
            else
            begin
                word = {acc_reg, value};
                case (pad_mid)
                    2'd0:    nbytes = 2'd3;
                    2'd1:    nbytes = 2'd2;
                    default: nbytes = 2'd1;
                endcase
                pos_mid = 2'd0;
                acc_mid = '0;
                pad_mid = 2'd0;
            end
        end

        // Text ending mid-quartet is a length error unless one is already held
        err_fin = err_mid;
        if (err_mid == ST_OK && pos_mid != 2'd0)
        begin
            err_fin = ST_BADLEN;
        end

        push_o.push             = in_acc && (nbytes != 2'd0 || last);
        push_o.entry.data       = word;
        push_o.entry.nbytes     = nbytes;
        push_o.entry.has_status = last;
        push_o.entry.code       = last ? err_fin : ST_OK;

        pos_next = pos_reg;
        acc_next = acc_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        if (in_acc)
        begin
            if (last)
            begin
                pos_next = 2'd0;
                acc_next = '0;
                pad_next = 2'd0;
                err_next = ST_OK;
            end
            else
            begin
                pos_next = pos_mid;
                acc_next = acc_mid;
                pad_next = pad_mid;
                err_next = err_mid;
            end
        end
    end

    // Hold quartet state between characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            acc_reg <= '0;
            pad_reg <= 2'd0;
            err_reg <= ST_OK;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end

    `ASSERT_IMPLIES(a_quiet_after_error, clk, rst_n, in_acc && err_reg != ST_OK && !in_ch.end_of_text, !push_o.push)
    `ASSERT_NEXT(a_clear_after_last, clk, rst_n, in_acc && in_ch.end_of_text, pos_reg == 2'd0 && pad_reg == 2'd0 && err_reg == ST_OK)

endmodule

>>> design/b64d_fifo.sv
`include "assert_macros.svh"

module b64d_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  b64d_pkg::push_t push_i,
    input  logic            pop,
    output logic            full,
    output b64d_pkg::head_t head
);
    import b64d_pkg::*;

    entry_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == FIFO_FULL_COUNT);
    assign head.avail = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push_i.push && !full;
    assign do_pop     = pop && head.avail;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_i.entry;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push_i.push, count_reg != FIFO_FULL_COUNT)

endmodule

>>> design/b64d_back.sv
`include "assert_macros.svh"

module b64d_back (
    input  logic            clk,
    input  logic            rst_n,
    input  b64d_pkg::head_t head,
    output logic            pop,
    b64d_out_if.source      out_ch
);
    import b64d_pkg::*;

    entry_t      cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        stat_reg, stat_next;
    status_t     code_reg, code_next;

    logic [2:0]  cur_total;
    logic        is_final;
    logic        load_out;
    logic [7:0]  sel_byte;

    assign cur_total = {1'b0, cur_reg.nbytes} + {2'b00, cur_reg.has_status};
    assign is_final  = ({1'b0, idx_reg} + 3'd1) == cur_total;
    assign load_out  = cur_valid_reg && (!out_valid_reg || out_ch.ready);

    // Pick the byte at the current position, high byte first
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = cur_reg.data[23:16];
            2'd1:    sel_byte = cur_reg.data[15:8];
            2'd2:    sel_byte = cur_reg.data[7:0];
            default: sel_byte = 8'd0;
        endcase
    end

    // Serialise the current entry into the output register
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        byte_next      = byte_reg;
        stat_next      = stat_reg;
        code_next      = code_reg;
        pop            = 1'b0;

        if (load_out)
        begin
            out_valid_next = 1'b1;
            if ({1'b0, idx_reg} < {1'b0, cur_reg.nbytes})
            begin
                byte_next = sel_byte;
                stat_next = 1'b0;
                code_next = ST_OK;
            end
            else
            begin
                byte_next = 8'd0;
                stat_next = 1'b1;
                code_next = cur_reg.code;
            end

            if (is_final)
            begin
                pop            = head.avail;
                cur_valid_next = head.avail;
                cur_next       = head.entry;
                idx_next       = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        else if (!cur_valid_reg && head.avail)
        begin
            pop            = 1'b1;
            cur_valid_next = 1'b1;
            cur_next       = head.entry;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        stat_reg <= stat_next;
        code_reg <= code_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.data_byte   = byte_reg;
    assign out_ch.is_status   = stat_reg;
    assign out_ch.status_code = code_reg;
    assign out_ch.last_result = stat_reg;

    `ASSERT_IMPLIES(a_entry_not_empty, clk, rst_n, cur_valid_reg, cur_total != 3'd0)
    `ASSERT_IMPLIES(a_index_in_range, clk, rst_n, cur_valid_reg, {1'b0, idx_reg} < cur_total)

endmodule

>>> design/base64_stream_decoder.sv
// Channel  Role   Payload
// in_ch    sink   char_code[7:0], end_of_text
// out_ch   source data_byte[7:0], is_status, status_code[1:0], last_result
//
// One character is taken per cycle while the four-entry queue has room.
// Each completed quartet yields up to three bytes and the final character one
// status transaction; the output register sends one transaction per cycle while out_ch.ready is high.
// A result passes through the queue, the current-entry register and the output register before it is offered.
// Reset is asynchronous, active low, and needs no clearing pass.
// A stall on out_ch fills the queue, after which in_ch.ready drops.
module base64_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    b64d_in_if.sink    in_ch,
    b64d_out_if.source out_ch
);
    import b64d_pkg::*;

    push_t push;
    head_t head;
    logic  full;
    logic  pop;

    b64d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .full   (full),
        .push_o (push)
    );

    b64d_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_i (push),
        .pop    (pop),
        .full   (full),
        .head   (head)
    );

    b64d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

>>> sim/base64_stream_decoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_decoder_tb;

    import b64d_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         CALM_TAIL      = 40;
    localparam logic [7:0] PAD_CHAR       = 8'h3D;

    typedef struct {
        logic [7:0] char_code;
        logic       end_of_text;
    } text_char_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_status;
        logic [1:0] status_code;
        logic       last_result;
    } decoded_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    b64d_in_if  in_ch ();
    b64d_out_if out_ch ();

    base64_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    text_char_t text_fifo[$];
    decoded_t   decoded_fifo[$];
    text_char_t next_char;
    decoded_t   head;

    // decoder state mirrored from the characters taken
    logic [1:0]  quad_pos  = 2'd0;
    logic [17:0] quad_bits = 18'd0;
    logic [1:0]  quad_pads = 2'd0;
    status_t     text_err  = ST_OK;

    int mismatch_count = 0;
    int chars_taken    = 0;
    int quiet_cycles   = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    always #5 clk = ~clk;

    function automatic void sextet_lookup(input logic [7:0] c, output logic [5:0] v,
                                          output logic pad, output logic bad);
        v   = 6'd0;
        pad = 1'b0;
        bad = 1'b0;
        if (c >= 8'h41 && c <= 8'h5A)
            v = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            v = 6'(c - 8'h47);
        else if (c >= 8'h30 && c <= 8'h39)
            v = 6'(c + 8'h04);
        else if (c == 8'h2B)
            v = 6'd62;
        else if (c == 8'h2F)
            v = 6'd63;
        else if (c == PAD_CHAR)
            pad = 1'b1;
        else
            bad = 1'b1;
    endfunction

    function automatic void push_decoded(input logic [7:0] b, input logic st,
                                         input status_t code);
        decoded_t r;
        r.data_byte   = b;
        r.is_status   = st;
        r.status_code = code;
        r.last_result = st;
        decoded_fifo.push_back(r);
    endfunction

    // advance the mirrored state by one character and queue what it yields
    function automatic void decode_char(input logic [7:0] c, input logic eot);
        logic [5:0]  sx;
        logic        pad;
        logic        bad;
        logic [23:0] word;
        int          nbytes;
        sextet_lookup(c, sx, pad, bad);
        if (text_err == ST_OK)
        begin
            if (bad)
                text_err = ST_BADCHAR;
            else if (pad)
            begin
                if (quad_pos < 2'd2 || (quad_pos == 2'd3 && !eot))
                    text_err = ST_BADPAD;
                else
                    quad_pads = quad_pads + 2'd1;
            end
            else if (quad_pads != 2'd0)
                text_err = ST_BADPAD;

            if (text_err == ST_OK)
            begin
                if (pad)
                    sx = 6'd0;
                if (quad_pos != 2'd3)
                begin
                    quad_bits = {quad_bits[11:0], sx};
                    quad_pos  = quad_pos + 2'd1;
                end
                else
                begin
                    word   = {quad_bits, sx};
                    nbytes = 3 - ((quad_pads > 2'd2) ? 2 : int'(quad_pads));
                    for (int i = 0; i < nbytes; i++)
                        push_decoded(word[23 - 8 * i -: 8], 1'b0, ST_OK);
                    quad_pos  = 2'd0;
                    quad_bits = 18'd0;
                    quad_pads = 2'd0;
                end
            end
        end

        // close the text with its status and start afresh
        if (eot)
        begin
            if (text_err == ST_OK && quad_pos != 2'd0)
                text_err = ST_BADLEN;
            push_decoded(8'h00, 1'b1, text_err);
            quad_pos  = 2'd0;
            quad_bits = 18'd0;
            quad_pads = 2'd0;
            text_err  = ST_OK;
        end
    endfunction

    function automatic void flag_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endfunction

    function automatic void queue_text(input logic [7:0] text[$]);
        text_char_t t;
        foreach (text[i])
        begin
            t.char_code   = text[i];
            t.end_of_text = (i == text.size() - 1);
            text_fifo.push_back(t);
        end
    endfunction

    function automatic void queue_string(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        queue_text(text);
    endfunction

    // feed characters, leaving random gaps between transactions
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.char_code   <= 8'h00;
            in_ch.end_of_text <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (text_fifo.size() != 0)
            begin
                next_char = text_fifo.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.char_code   <= next_char.char_code;
                in_ch.end_of_text <= next_char.end_of_text;
                if (text_fifo.size() >= CALM_TAIL && hold_left == 0 &&
                    $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 10);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // accept results, with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && chars_taken >= 100)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (text_fifo.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 10);
        end
    end

    // predict on each character taken, check each result sent
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_char(in_ch.char_code, in_ch.end_of_text);
                chars_taken++;
            end

            if (out_ch.valid && out_ch.ready)
            begin
                if (decoded_fifo.size() == 0)
                begin
                    mismatch_count++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual byte 0x%0h status %0b code %0d last %0b"},
                             $time, out_ch.data_byte, out_ch.is_status,
                             out_ch.status_code, out_ch.last_result);
                end
                else
                begin
                    head = decoded_fifo.pop_front();
                    flag_field("data_byte", head.data_byte, out_ch.data_byte);
                    flag_field("is_status", 8'(head.is_status), 8'(out_ch.is_status));
                    flag_field("status_code", 8'(head.status_code), 8'(out_ch.status_code));
                    flag_field("last_result", 8'(head.last_result), 8'(out_ch.last_result));
                end
            end

            // end the run if nothing moves for too long
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] text[$];
        int         kind;
        int         quartets;
        int         pads;
        int         spot;

        // alphabet edges, both padding forms and each error
        queue_string("AZaz09+/");
        queue_string("QQ==");
        queue_string("QUI=");
        queue_string("ABC=D");
        text.delete();
        text.push_back(8'h00);
        text.push_back(8'hFF);
        queue_text(text);
        queue_string("=");
        queue_string("AB");

        // mostly well-formed texts, some broken, a little noise
        while (text_fifo.size() < 260)
        begin
            text.delete();
            kind = $urandom_range(0, 19);
            if (kind < 3)
            begin
                repeat ($urandom_range(1, 6))
                    text.push_back(($urandom_range(0, 3) == 0) ? PAD_CHAR
                                                               : 8'($urandom_range(0, 255)));
            end
            else
            begin
                quartets = $urandom_range(1, 3);
                repeat (4 * quartets)
                    text.push_back(alphabet[$urandom_range(0, 63)]);
                pads = $urandom_range(0, 2);
                for (int p = 0; p < pads; p++)
                    text[text.size() - 1 - p] = PAD_CHAR;
                if (kind >= 15)
                begin
                    spot = $urandom_range(0, text.size() - 1);
                    case ($urandom_range(0, 3))
                        0: text[spot] = 8'($urandom_range(0, 255));
                        1: text[spot] = PAD_CHAR;
                        2: text.insert(spot, alphabet[$urandom_range(0, 63)]);
                        default:
                            repeat ($urandom_range(1, 3))
                                void'(text.pop_back());
                    endcase
                end
            end
            queue_text(text);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain the stimulus, then the predicted results, then settle
        @(posedge clk);
        while (text_fifo.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (decoded_fifo.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_front.sv
design/b64d_fifo.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
sim/base64_stream_decoder_tb.sv
